FILE: rtl/core/swfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_pkg
// shared constants, register indexes and control bundles of the sync word
// frame parser
// ----------------------------------------------------------------------------
package swfp_pkg;

  localparam int FRAME_LEN_DEF = 32;
  localparam int BYTE_W        = 8;
  localparam int CFG_IDX_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_VALUE = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'hEB;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'h90;
  localparam logic [BYTE_W-1:0] TRAILER_VALUE_RST = 8'h20;

  // front -> frame buffer
  typedef struct packed {
    logic wr_en;
    logic commit;
  } wr_ctl_t;

  // back -> frame buffer
  typedef struct packed {
    logic rd_en;
    logic done;
  } rd_ctl_t;

  // frame buffer status
  typedef struct packed {
    logic wr_free;
    logic avail;
  } buf_st_t;

endpackage

FILE: rtl/core/swfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_front
// sync hunt and frame fill: classifies each received byte and writes the
// frame into the free buffer bank, committing it on a trailer match
// ----------------------------------------------------------------------------
module swfp_front #(
  parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF,
  localparam int IDX_W    = $clog2(FRAME_LEN)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [swfp_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic [swfp_pkg::BYTE_W-1:0] sync_first,
  input  logic [swfp_pkg::BYTE_W-1:0] sync_second,
  input  logic [swfp_pkg::BYTE_W-1:0] trailer_value,
  input  swfp_pkg::buf_st_t           buf_st,
  output swfp_pkg::wr_ctl_t           wr_ctl,
  output logic [IDX_W-1:0]            wr_idx,
  output logic [swfp_pkg::BYTE_W-1:0] wr_data
);

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_FILL,
    PH_TRAIL
  } phase_t;

  // frame is full right after the second sync byte only for tiny frames
  localparam logic SHORT_FRAME = (FRAME_LEN <= 3);

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;

  assign in_stall = !buf_st.wr_free;
  assign accept   = in_valid && buf_st.wr_free;
  assign wr_data  = in_rx_byte;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    wr_ctl    = '0;
    wr_idx    = idx_r;
    if (accept) begin
      case (phase_r)
        PH_HUNT1: begin
          if (in_rx_byte == sync_first) begin
            wr_ctl.wr_en = 1'b1;
            wr_idx       = '0;
            idx_nxt      = IDX_W'(1);
            phase_nxt    = PH_HUNT2;
          end
        end
        PH_HUNT2: begin
          if (in_rx_byte == sync_second) begin
            wr_ctl.wr_en = 1'b1;
            wr_idx       = IDX_W'(1);
            idx_nxt      = IDX_W'(2);
            phase_nxt    = SHORT_FRAME ? PH_TRAIL : PH_FILL;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_FILL: begin
          wr_ctl.wr_en = 1'b1;
          idx_nxt      = idx_r + IDX_W'(1);
          if (idx_r == IDX_W'(FRAME_LEN - 2)) begin
            phase_nxt = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          // mismatching trailer drops the frame silently
          if (in_rx_byte == trailer_value) begin
            wr_ctl.wr_en  = 1'b1;
            wr_ctl.commit = 1'b1;
            wr_idx        = IDX_W'(FRAME_LEN - 1);
          end
          phase_nxt = PH_HUNT1;
        end
        default: begin
          phase_nxt = PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

FILE: rtl/core/swfp_frame_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_frame_buf
// two-bank frame memory acting as the queue between front and back; a bank
// is full from commit until the back has read its last byte
// ----------------------------------------------------------------------------
module swfp_frame_buf #(
  parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF,
  localparam int IDX_W    = $clog2(FRAME_LEN),
  localparam int ADDR_W   = $clog2(2 * FRAME_LEN)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swfp_pkg::wr_ctl_t           wr_ctl,
  input  logic [IDX_W-1:0]            wr_idx,
  input  logic [swfp_pkg::BYTE_W-1:0] wr_data,
  input  swfp_pkg::rd_ctl_t           rd_ctl,
  input  logic [IDX_W-1:0]            rd_idx,
  output logic [swfp_pkg::BYTE_W-1:0] rd_data,
  output swfp_pkg::buf_st_t           buf_st
);

  logic [swfp_pkg::BYTE_W-1:0] mem [2*FRAME_LEN];

  logic        wbank_r;
  logic        rbank_r;
  logic [1:0]  full_r;
  logic [1:0]  full_nxt;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign wr_addr = wbank_r ? ADDR_W'(FRAME_LEN) + ADDR_W'(wr_idx) : ADDR_W'(wr_idx);
  assign rd_addr = rbank_r ? ADDR_W'(FRAME_LEN) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

  assign buf_st.wr_free = !full_r[wbank_r];
  assign buf_st.avail   = full_r[rbank_r];

  always_comb begin
    full_nxt = full_r;
    if (wr_ctl.commit) begin
      full_nxt[wbank_r] = 1'b1;
    end
    if (rd_ctl.done) begin
      full_nxt[rbank_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wbank_r <= 1'b0;
      rbank_r <= 1'b0;
      full_r  <= '0;
    end else begin
      full_r <= full_nxt;
      if (wr_ctl.commit) begin
        wbank_r <= !wbank_r;
      end
      if (rd_ctl.done) begin
        rbank_r <= !rbank_r;
      end
    end
  end

endmodule

FILE: rtl/core/swfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swfp_back
// frame replay: reads a committed bank byte by byte into the output
// register, marking the final byte
// ----------------------------------------------------------------------------
module swfp_back #(
  parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF,
  localparam int IDX_W    = $clog2(FRAME_LEN)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swfp_pkg::buf_st_t           buf_st,
  output swfp_pkg::rd_ctl_t           rd_ctl,
  output logic [IDX_W-1:0]            rd_idx,
  input  logic [swfp_pkg::BYTE_W-1:0] rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swfp_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                        out_frame_last
);

  logic [IDX_W-1:0]            rd_idx_r;
  logic [IDX_W-1:0]            rd_idx_nxt;
  logic                        pend_r;
  logic                        pend_last_r;
  logic                        out_valid_r;
  logic [swfp_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_last_r;
  logic                        out_take;
  logic                        issue;
  logic                        is_last;

  assign out_take = out_valid_r && !out_stall;
  // one read in flight; it may only start when the output slot will be empty
  assign issue    = buf_st.avail && !pend_r && (!out_valid_r || out_take);
  assign is_last  = (rd_idx_r == IDX_W'(FRAME_LEN - 1));

  assign rd_ctl.rd_en = issue;
  assign rd_ctl.done  = issue && is_last;
  assign rd_idx       = rd_idx_r;
  assign rd_idx_nxt   = is_last ? '0 : rd_idx_r + IDX_W'(1);

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_last_r <= is_last;
    end
    if (pend_r) begin
      out_byte_r <= rd_data;
      out_last_r <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= issue;
      if (issue) begin
        rd_idx_r <= rd_idx_nxt;
      end
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/sync_word_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_frame_parser
// hunts a two-byte sync word, collects a FRAME_LEN-byte frame, checks its
// final byte against a trailer value and replays accepted frames
// ----------------------------------------------------------------------------
// Received bytes are taken at one per cycle while hunting and filling; the
// input only stalls when both frame banks hold accepted frames not yet fully
// replayed. An accepted frame is replayed as FRAME_LEN result requests with
// one read in flight on the single frame memory read port. The first byte
// passes the bank full flag, the read register and the output register after
// the trailer byte is taken. Filling of the next frame overlaps replay of the
// previous one through the second bank. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module sync_word_frame_parser #(
  parameter int FRAME_LEN = swfp_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // received byte requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [swfp_pkg::BYTE_W-1:0]    in_rx_byte,
  // replayed frame byte requests
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [swfp_pkg::BYTE_W-1:0]    out_frame_byte,
  output logic                           out_frame_last,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swfp_pkg::BYTE_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(FRAME_LEN);

  logic [swfp_pkg::BYTE_W-1:0] sync_first_r;
  logic [swfp_pkg::BYTE_W-1:0] sync_second_r;
  logic [swfp_pkg::BYTE_W-1:0] trailer_value_r;

  swfp_pkg::wr_ctl_t           wr_ctl;
  swfp_pkg::rd_ctl_t           rd_ctl;
  swfp_pkg::buf_st_t           buf_st;
  logic [IDX_W-1:0]            wr_idx;
  logic [IDX_W-1:0]            rd_idx;
  logic [swfp_pkg::BYTE_W-1:0] wr_data;
  logic [swfp_pkg::BYTE_W-1:0] rd_data;

  // config writes are always accepted and registered; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r    <= swfp_pkg::SYNC_FIRST_RST;
      sync_second_r   <= swfp_pkg::SYNC_SECOND_RST;
      trailer_value_r <= swfp_pkg::TRAILER_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swfp_pkg::REG_SYNC_FIRST:    sync_first_r    <= cfg_wdata;
        swfp_pkg::REG_SYNC_SECOND:   sync_second_r   <= cfg_wdata;
        swfp_pkg::REG_TRAILER_VALUE: trailer_value_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front: sync hunt and frame fill
  swfp_front #(
    .FRAME_LEN(FRAME_LEN)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .sync_first   (sync_first_r),
    .sync_second  (sync_second_r),
    .trailer_value(trailer_value_r),
    .buf_st       (buf_st),
    .wr_ctl       (wr_ctl),
    .wr_idx       (wr_idx),
    .wr_data      (wr_data)
  );

  // two-bank frame memory between the halves
  swfp_frame_buf #(
    .FRAME_LEN(FRAME_LEN)
  ) u_frame_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_ctl (wr_ctl),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_ctl (rd_ctl),
    .rd_idx (rd_idx),
    .rd_data(rd_data),
    .buf_st (buf_st)
  );

  // back: frame replay
  swfp_back #(
    .FRAME_LEN(FRAME_LEN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .buf_st        (buf_st),
    .rd_ctl        (rd_ctl),
    .rd_idx        (rd_idx),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last)
  );

  // front never writes into a bank still waiting for replay
  a_wr_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ctl.wr_en |-> buf_st.wr_free)
    else $error("frame write into an occupied bank");

  // back only reads a committed bank
  a_rd_bank_avail: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctl.rd_en |-> buf_st.avail)
    else $error("frame read from an empty bank");

  // a sync_first write takes effect on the next cycle
  a_cfg_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == swfp_pkg::REG_SYNC_FIRST)
    |=> sync_first_r == $past(cfg_wdata))
    else $error("sync_first register not updated");

endmodule

FILE: tb/frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// follows the received byte and configuration requests, predicts the frames
// the parser must replay and compares every replayed byte request with them
// ----------------------------------------------------------------------------
module frame_checker #(
  parameter int FLEN = swfp_pkg::FRAME_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [swfp_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [swfp_pkg::BYTE_W-1:0]    out_frame_byte,
  input  logic                           out_frame_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [swfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swfp_pkg::BYTE_W-1:0]    cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    bytes_outstanding
);

  typedef enum logic [1:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    FILLING,
    AWAIT_TRAILER
  } hunt_state_t;

  typedef struct packed {
    logic [swfp_pkg::BYTE_W-1:0] frame_byte;
    logic                        frame_last;
  } replay_byte_t;

  hunt_state_t                 hunt_state;
  logic [5:0]                  fill_count;
  logic [swfp_pkg::BYTE_W-1:0] frame_store [FLEN];
  logic [swfp_pkg::BYTE_W-1:0] sync_first;
  logic [swfp_pkg::BYTE_W-1:0] sync_second;
  logic [swfp_pkg::BYTE_W-1:0] trailer_value;
  replay_byte_t                replay_q [$];
  int unsigned                 mismatches;

  task store_byte(input logic [swfp_pkg::BYTE_W-1:0] b);
    if (int'(fill_count) < FLEN) begin
      frame_store[fill_count] = b;
      fill_count = fill_count + 6'd1;
    end
  endtask

  // advance the parser by one received byte, queue the replay on a good trailer
  task take_rx_byte(input logic [swfp_pkg::BYTE_W-1:0] b);
    replay_byte_t entry;
    case (hunt_state)
      HUNT_FIRST: begin
        if (b == sync_first) begin
          fill_count = '0;
          store_byte(b);
          hunt_state = HUNT_SECOND;
        end
      end
      HUNT_SECOND: begin
        if (b == sync_second) begin
          store_byte(b);
          hunt_state = (int'(fill_count) >= FLEN - 1) ? AWAIT_TRAILER : FILLING;
        end else begin
          hunt_state = HUNT_FIRST;
          fill_count = '0;
        end
      end
      FILLING: begin
        store_byte(b);
        if (int'(fill_count) >= FLEN - 1) hunt_state = AWAIT_TRAILER;
      end
      default: begin
        if (b == trailer_value) begin
          store_byte(b);
          for (int i = 0; i < FLEN; i++) begin
            entry.frame_byte = frame_store[i];
            entry.frame_last = (i == FLEN - 1);
            replay_q.push_back(entry);
          end
        end
        hunt_state = HUNT_FIRST;
        fill_count = '0;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    replay_byte_t want;
    if (!rst_n) begin
      hunt_state    = HUNT_FIRST;
      fill_count    = '0;
      sync_first    = swfp_pkg::SYNC_FIRST_RST;
      sync_second   = swfp_pkg::SYNC_SECOND_RST;
      trailer_value = swfp_pkg::TRAILER_VALUE_RST;
      replay_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swfp_pkg::REG_SYNC_FIRST:    sync_first = cfg_wdata;
          swfp_pkg::REG_SYNC_SECOND:   sync_second = cfg_wdata;
          swfp_pkg::REG_TRAILER_VALUE: trailer_value = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) take_rx_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (replay_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected frame byte %02h last %0b", out_frame_byte, out_frame_last);
        end else begin
          want = replay_q.pop_front();
          if (out_frame_byte !== want.frame_byte || out_frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                       want.frame_byte, want.frame_last, out_frame_byte, out_frame_last);
          end
        end
      end
    end
    fail_count        <= mismatches;
    bytes_outstanding <= replay_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// feeds the sync word frame parser with byte streams of good frames, frames
// with a wrong trailer or a wrong second sync byte and line noise, under
// several register settings and random idling on both sides
// ----------------------------------------------------------------------------
module testbench;

  localparam int FLEN        = swfp_pkg::FRAME_LEN_DEF;
  localparam int BW          = swfp_pkg::BYTE_W;
  localparam int IW          = swfp_pkg::CFG_IDX_W;
  // index past the register list, writes to it must be dropped
  localparam logic [IW-1:0] REG_SPARE = 2'd3;
  localparam int LONG_HOLD   = 240;  // receiver hold-off for the back-pressure phase
  localparam int SETTLE      = 12;   // margin for the replay pipeline at the end of each phase
  localparam int PHASE_ITEMS = 32;   // counted byte requests per register setting

  typedef enum int {
    GOOD_FRAME,
    BAD_TRAILER,
    BAD_SECOND,
    LINE_NOISE
  } burst_kind_t;

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_stall;
  logic [BW-1:0] in_rx_byte     = '0;
  logic          out_valid;
  logic          out_stall      = 1'b0;
  logic [BW-1:0] out_frame_byte;
  logic          out_frame_last;
  logic          cfg_valid      = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index      = '0;
  logic [BW-1:0] cfg_wdata      = '0;

  int unsigned fail_count;
  int unsigned bytes_outstanding;

  // register values as last programmed, used to shape the byte streams
  logic [BW-1:0] cur_sf = swfp_pkg::SYNC_FIRST_RST;
  logic [BW-1:0] cur_ss = swfp_pkg::SYNC_SECOND_RST;
  logic [BW-1:0] cur_tv = swfp_pkg::TRAILER_VALUE_RST;

  int unsigned sent_items = 0;
  logic        idle_on    = 1'b1;
  logic        hold_req   = 1'b0;

  sync_word_frame_parser #(
    .FRAME_LEN(FLEN)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  frame_checker #(
    .FLEN(FLEN)
  ) replay_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_byte   (out_frame_byte),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .bytes_outstanding(bytes_outstanding)
  );

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // hard stop in case the parser hangs
  initial begin : watchdog
    #400us;
    $display("== FAIL ==");
    $finish;
  end

  // result side: short random stall bursts, one long hold-off on request
  initial begin : result_sink
    int unsigned burst_left;
    bit          held;
    burst_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        // long hold so both frame banks fill and the input side stalls
        out_stall <= 1'b1;
        held = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        burst_left = 0;
      end else if (burst_left != 0) begin
        burst_left--;
        if (burst_left == 0) out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 8);
      end
    end
  end

  // one received byte request, with an optional idle burst ahead of it
  task automatic push_rx(input logic [BW-1:0] b, input bit counted = 1'b1);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) sent_items++;
  endtask

  // raise or keep the write request up until the register is taken
  task automatic cfg_write(input logic [IW-1:0] idx, input logic [BW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [BW-1:0] sf, ss, tv);
    cfg_write(swfp_pkg::REG_SYNC_FIRST, sf);
    cfg_write(swfp_pkg::REG_SYNC_SECOND, ss);
    cfg_write(swfp_pkg::REG_TRAILER_VALUE, tv);
    cfg_write(REG_SPARE, BW'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    cur_sf = sf;
    cur_ss = ss;
    cur_tv = tv;
  endtask

  // wait until every predicted replay byte is out, plus a margin for the
  // pipeline when the last bytes caused no replay
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_burst(input burst_kind_t kind);
    logic [BW-1:0] b;
    case (kind)
      LINE_NOISE: begin
        // mostly non-sync bytes, now and then a stray first sync byte
        repeat ($urandom_range(1, 4)) begin
          do b = BW'($urandom_range(0, 255)); while (b == cur_sf && $urandom_range(0, 7) != 0);
          push_rx(b, 1'b0);
        end
      end
      BAD_SECOND: begin
        push_rx(cur_sf);
        do b = BW'($urandom_range(0, 255)); while (b == cur_ss);
        push_rx(b);
      end
      default: begin
        push_rx(cur_sf);
        push_rx(cur_ss);
        repeat (FLEN - 3) push_rx(BW'($urandom_range(0, 255)));
        if (kind == GOOD_FRAME) begin
          push_rx(cur_tv);
        end else begin
          do b = BW'($urandom_range(0, 255)); while (b == cur_tv);
          push_rx(b);
        end
      end
    endcase
  endtask

  // mostly well-formed frames with random payload, the rest broken or noise
  task automatic run_random(input int unsigned goal);
    int unsigned pick;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      send_burst(GOOD_FRAME);
      else if (pick < 72) send_burst(BAD_TRAILER);
      else if (pick < 84) send_burst(BAD_SECOND);
      else                send_burst(LINE_NOISE);
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    // noise at both byte extremes while hunting
    push_rx(8'h00, 1'b0);
    push_rx(8'hFF, 1'b0);
    // wrong second byte that is itself a first sync byte, not re-examined
    push_rx(swfp_pkg::SYNC_FIRST_RST);
    push_rx(swfp_pkg::SYNC_FIRST_RST);
    // so this second sync byte falls on a hunting parser and is ignored
    push_rx(swfp_pkg::SYNC_SECOND_RST, 1'b0);
    // full frame with alternating all-zero and all-one payload
    push_rx(swfp_pkg::SYNC_FIRST_RST);
    push_rx(swfp_pkg::SYNC_SECOND_RST);
    for (int i = 0; i < FLEN - 3; i++) push_rx(i[0] ? 8'hFF : 8'h00);
    push_rx(swfp_pkg::TRAILER_VALUE_RST);

    // back-pressure: long receiver hold while frames keep coming
    hold_req <= 1'b1;
    repeat (2) send_burst(GOOD_FRAME);
    send_burst(BAD_TRAILER);

    settle();
    program_regs(8'h00, 8'hFF, 8'h00);
    run_random(sent_items + PHASE_ITEMS);

    settle();
    program_regs(8'hFF, 8'h00, 8'hFF);
    run_random(sent_items + PHASE_ITEMS);

    // sync bytes and trailer all alike
    settle();
    program_regs(8'h5A, 8'h5A, 8'h5A);
    run_random(sent_items + PHASE_ITEMS);

    // random setting, no idling on either side from here on
    settle();
    program_regs(BW'($urandom_range(0, 255)), BW'($urandom_range(0, 255)),
                 BW'($urandom_range(0, 255)));
    idle_on <= 1'b0;
    run_random(sent_items + PHASE_ITEMS);

    settle();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
